@@ rtl/core/r4t_pkg.sv @@
// shared types and constants for the rgba8 4x4 tiler
// no dependencies; used by every module under rtl/core except r4t_band_ram
`default_nettype none

package r4t_pkg;

    localparam int TILE_SIDE = 4;
    localparam int TILE_CAP = 256;
    localparam int WORDS_PER_TILE = 32;
    localparam int CFG_W = 9;
    localparam int CNT_W = 10;
    localparam int WIDX_W = 5;

    localparam logic [CFG_W-1:0] WIDTH_TILES_RST = 9'd160;
    localparam logic [CFG_W-1:0] HEIGHT_TILES_RST = 9'd100;

    typedef enum logic {
        CFG_WIDTH_TILES = 1'b0,
        CFG_HEIGHT_TILES = 1'b1
    } cfg_reg_t;

    // handed from the pixel counter to the tile reader on the completing pixel
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] base_col;
        logic             frame_end;
    } tile_req_t;

endpackage

`default_nettype wire

@@ rtl/core/r4t_band_ram.sv @@
// band store: single write port, single read port, registered read data
// no package dependency
`default_nettype none

module r4t_band_ram #(
    parameter int DEPTH = 4096,
    parameter int AW = 12,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/core/r4t_pixel_counter.sv @@
// frame size registers, column/row counters and band write address
// depends on r4t_pkg
`default_nettype none

module r4t_pixel_counter #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW = 12
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [r4t_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic                         pix_accept,
    output logic                              wr_en,
    output logic      [AW-1:0]                wr_addr,
    output r4t_pkg::tile_req_t                tile_req
);

    localparam int WcapRaw = MAX_WIDTH / r4t_pkg::TILE_SIDE;
    localparam int WcapLim = (WcapRaw > r4t_pkg::TILE_CAP) ? r4t_pkg::TILE_CAP : WcapRaw;
    localparam int Wcap = (WcapLim < 1) ? 1 : WcapLim;
    localparam int CW = r4t_pkg::CNT_W;

    logic [r4t_pkg::CFG_W-1:0] width_tiles_reg, width_tiles_next;
    logic [r4t_pkg::CFG_W-1:0] height_tiles_reg, height_tiles_next;
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic [r4t_pkg::CFG_W-1:0] w_eff, h_eff;
    logic [CW:0] wpx, hpx, col_inc, row_inc;
    logic col_wrap, row_wrap, col_ok;

    // zero acts as one tile, large values saturate
    always_comb begin
        if (width_tiles_reg == '0) begin
            w_eff = r4t_pkg::CFG_W'(1);
        end else if (width_tiles_reg > r4t_pkg::CFG_W'(Wcap)) begin
            w_eff = r4t_pkg::CFG_W'(Wcap);
        end else begin
            w_eff = width_tiles_reg;
        end
        if (height_tiles_reg == '0) begin
            h_eff = r4t_pkg::CFG_W'(1);
        end else if (height_tiles_reg > r4t_pkg::CFG_W'(r4t_pkg::TILE_CAP)) begin
            h_eff = r4t_pkg::CFG_W'(r4t_pkg::TILE_CAP);
        end else begin
            h_eff = height_tiles_reg;
        end
    end

    assign wpx = (CW+1)'({w_eff, 2'b00});
    assign hpx = (CW+1)'({h_eff, 2'b00});
    assign col_inc = {1'b0, col_reg} + (CW+1)'(1);
    assign row_inc = {1'b0, row_reg} + (CW+1)'(1);
    assign col_wrap = (col_inc >= wpx);
    assign row_wrap = (row_inc >= hpx);
    assign col_ok = ({22'd0, col_reg} < 32'(MAX_WIDTH));

    always_comb begin
        width_tiles_next = width_tiles_reg;
        height_tiles_next = height_tiles_reg;
        if (cfg_write) begin
            unique case (r4t_pkg::cfg_reg_t'(cfg_index))
                r4t_pkg::CFG_WIDTH_TILES: width_tiles_next = cfg_data;
                r4t_pkg::CFG_HEIGHT_TILES: height_tiles_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept) begin
            if (col_wrap) begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_inc[CW-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_tiles_reg <= r4t_pkg::WIDTH_TILES_RST;
            height_tiles_reg <= r4t_pkg::HEIGHT_TILES_RST;
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            width_tiles_reg <= width_tiles_next;
            height_tiles_reg <= height_tiles_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign wr_en = pix_accept && col_ok;
    assign wr_addr = AW'(row_reg[1:0]) * AW'(MAX_WIDTH) + AW'(col_reg);

    assign tile_req.start = pix_accept && col_ok && (col_reg[1:0] == 2'b11)
                            && (row_reg[1:0] == 2'b11);
    assign tile_req.base_col = col_reg - CW'(3);
    assign tile_req.frame_end = col_wrap && row_wrap;

endmodule

`default_nettype wire

@@ rtl/core/r4t_tile_reader.sv @@
// tile read sequencer: 32 band reads per tile, plane split and output register
// depends on r4t_pkg
`default_nettype none

module r4t_tile_reader #(
    parameter int MAX_WIDTH = 1024,
    parameter int AW = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire r4t_pkg::tile_req_t tile_req,
    output logic                    busy,
    output logic      [AW-1:0]      rd_addr,
    input  wire logic [31:0]        rd_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [15:0]        m_tiled_word,
    output logic                    m_plane,
    output logic                    m_last_in_tile,
    output logic                    m_last_in_frame
);

    localparam int IW = r4t_pkg::WIDX_W;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [IW:0] issue_cnt_reg, issue_cnt_next;
    logic s1_valid_reg, s1_valid_next;
    logic [IW-1:0] s1_idx_reg, s1_idx_next;
    logic [r4t_pkg::CNT_W-1:0] base_reg, base_next;
    logic frame_end_reg, frame_end_next;
    logic m_valid_reg, m_valid_next;
    logic [15:0] word_reg, word_next;
    logic plane_reg, plane_next;
    logic last_tile_reg, last_tile_next;
    logic last_frame_reg, last_frame_next;

    logic advance, issuing, s1_last;
    logic [IW-1:0] fetch_idx;

    function automatic logic [AW-1:0] word_addr(input logic [IW-1:0] idx,
                                                 input logic [r4t_pkg::CNT_W-1:0] base);
        word_addr = AW'(idx[3:2]) * AW'(MAX_WIDTH) + AW'(base) + AW'(idx[1:0]);
    endfunction

    assign advance = !m_valid_reg || m_ready;
    assign issuing = (state_reg == ST_EMIT)
                     && (issue_cnt_reg < (IW+1)'(r4t_pkg::WORDS_PER_TILE));
    // on a stall the held stage re-reads its own entry
    assign fetch_idx = advance ? issue_cnt_reg[IW-1:0] : s1_idx_reg;
    assign rd_addr = word_addr(fetch_idx, base_reg);
    assign s1_last = (s1_idx_reg == IW'(r4t_pkg::WORDS_PER_TILE - 1));

    always_comb begin
        state_next = state_reg;
        issue_cnt_next = issue_cnt_reg;
        s1_valid_next = s1_valid_reg;
        s1_idx_next = s1_idx_reg;
        base_next = base_reg;
        frame_end_next = frame_end_reg;
        m_valid_next = m_valid_reg;
        word_next = word_reg;
        plane_next = plane_reg;
        last_tile_next = last_tile_reg;
        last_frame_next = last_frame_reg;

        if (advance) begin
            m_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                plane_next = s1_idx_reg[4];
                word_next = s1_idx_reg[4] ? {rd_data[15:8], rd_data[23:16]}
                                          : {rd_data[31:24], rd_data[7:0]};
                last_tile_next = s1_last;
                last_frame_next = s1_last && frame_end_reg;
            end
            s1_valid_next = issuing;
            s1_idx_next = issue_cnt_reg[IW-1:0];
            if (issuing) begin
                issue_cnt_next = issue_cnt_reg + (IW+1)'(1);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (tile_req.start) begin
                    state_next = ST_EMIT;
                    issue_cnt_next = '0;
                    base_next = tile_req.base_col;
                    frame_end_next = tile_req.frame_end;
                end
            end
            ST_EMIT: begin
                if (advance && !issuing && s1_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            issue_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg <= m_valid_next;
        end
        s1_idx_reg <= s1_idx_next;
        base_reg <= base_next;
        frame_end_reg <= frame_end_next;
        word_reg <= word_next;
        plane_reg <= plane_next;
        last_tile_reg <= last_tile_next;
        last_frame_reg <= last_frame_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_tiled_word = word_reg;
    assign m_plane = plane_reg;
    assign m_last_in_tile = last_tile_reg;
    assign m_last_in_frame = last_frame_reg;

`ifndef NO_ASSERTIONS
    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tile_req.start |-> (state_reg == ST_IDLE))
        else $error("tile start while emitting");

    a_frame_implies_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && last_frame_reg |-> last_tile_reg && plane_reg)
        else $error("frame end flag off the last word of a tile");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("read stage moved during output stall");

    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !s1_valid_reg)
        else $error("read stage busy in idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/rgba8_four_by_four_tiler.sv @@
// rgba8 4x4 tiler: pixels in raster order, 16-bit AR then GB plane words per tile
// tile output: a tile-closing pixel starts a tile read; each word passes the band
// read stage and output register, 32 words at one per cycle while m_ready is high
// throughput: one pixel per cycle, except that the band store read port is busy
// with the tile read after each tile-closing pixel, during which no pixel is taken
// reset: counters to zero, width 160 and height 100 tiles, band store not cleared
`default_nettype none

module rgba8_four_by_four_tiler #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    // pixel request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,
    // tiled word request channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [15:0] m_tiled_word,
    output logic             m_plane,
    output logic             m_last_in_tile,
    output logic             m_last_in_frame
);

    // four band rows of MAX_WIDTH pixels each
    localparam int Depth = 4 * MAX_WIDTH;
    localparam int AW = $clog2(Depth);

    logic pix_accept;
    logic busy;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [31:0] rd_data;
    r4t_pkg::tile_req_t tile_req;

    // registers may be written at any time; the user keeps writes to idle periods
    assign cfg_ready = 1'b1;

    // no pixel is taken while the tile reader has the read port
    assign s_ready = !busy;
    assign pix_accept = s_valid && s_ready;

    // column/row tracking, frame size registers and the band write address
    r4t_pixel_counter #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW(AW)
    ) u_counter (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pix_accept(pix_accept),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .tile_req(tile_req)
    );

    // the pixel is written in its accept cycle, before any read of its tile
    r4t_band_ram #(
        .DEPTH(Depth),
        .AW(AW),
        .DW(32)
    ) u_band (
        .aclk(aclk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data({s_byte3, s_byte2, s_byte1, s_byte0}),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // each band entry is read twice: once for the AR plane, once for GB
    r4t_tile_reader #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW(AW)
    ) u_reader (
        .aclk(aclk),
        .aresetn(aresetn),
        .tile_req(tile_req),
        .busy(busy),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_tiled_word(m_tiled_word),
        .m_plane(m_plane),
        .m_last_in_tile(m_last_in_tile),
        .m_last_in_frame(m_last_in_frame)
    );

endmodule

`default_nettype wire
